// ===== design/vcds_pkg.sv =====
// Shared constants and width helpers for the vector similarity core.
package vcds_pkg;

  localparam int MAX_LEN_DEF    = 64;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int Q_DEPTH        = 4;
  localparam int COS_W          = 16;
  localparam int DIST_W         = 15;
  localparam int FRAC_OUT       = 15;

  // accumulator width: products plus growth over the vector length plus headroom
  function automatic int acc_width(input int ew, input int ml);
    return 2 * ew + $clog2(ml) + 2;
  endfunction

endpackage

// ===== design/vcds_front.sv =====
// Front end: element MACs, length tracking and hand-off of finished sums.
module vcds_front #(
  parameter int MAX_LEN    = 64,
  parameter int ELEM_WIDTH = 16,
  parameter int ACC_W      = 39
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic signed [ELEM_WIDTH-1:0] elem_a,
  input  logic signed [ELEM_WIDTH-1:0] elem_b,
  input  logic                         last_elem,
  output logic                         push,
  output logic [4*ACC_W:0]             push_data
);
  import vcds_pkg::*;

  localparam int EW    = ELEM_WIDTH;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0]       cnt_r;
  logic                   ovf_r;
  logic                   use_elem;
  logic signed [2*EW-1:0] prod_ab, prod_aa, prod_bb;
  logic signed [EW:0]     diff;
  logic signed [2*EW+1:0] prod_dd;

  logic                   s1_valid_r, s1_last_r, s1_ovf_r;
  logic signed [2*EW-1:0] pab_r;
  logic [2*EW-1:0]        paa_r, pbb_r;
  logic [2*EW:0]          pdd_r;

  logic signed [ACC_W-1:0] dot_r, dot_nxt;
  logic [ACC_W-1:0]        na_r, na_nxt, nb_r, nb_nxt, dsq_r, dsq_nxt;

  assign use_elem = (cnt_r < CNT_W'(MAX_LEN));
  assign prod_ab  = elem_a * elem_b;
  assign prod_aa  = elem_a * elem_a;
  assign prod_bb  = elem_b * elem_b;
  assign diff     = {elem_a[EW-1], elem_a} - {elem_b[EW-1], elem_b};
  assign prod_dd  = diff * diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        if (last_elem) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else if (use_elem) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // product stage; elements past the limit contribute nothing
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= last_elem;
      s1_ovf_r  <= ovf_r | ~use_elem;
      pab_r     <= use_elem ? prod_ab : '0;
      paa_r     <= use_elem ? prod_aa : '0;
      pbb_r     <= use_elem ? prod_bb : '0;
      pdd_r     <= use_elem ? prod_dd[2*EW:0] : '0;
    end
  end

  assign dot_nxt = dot_r + ACC_W'(pab_r);
  assign na_nxt  = na_r + {{(ACC_W-2*EW){1'b0}}, paa_r};
  assign nb_nxt  = nb_r + {{(ACC_W-2*EW){1'b0}}, pbb_r};
  assign dsq_nxt = dsq_r + {{(ACC_W-2*EW-1){1'b0}}, pdd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      dsq_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        dot_r <= '0;
        na_r  <= '0;
        nb_r  <= '0;
        dsq_r <= '0;
      end else begin
        dot_r <= dot_nxt;
        na_r  <= na_nxt;
        nb_r  <= nb_nxt;
        dsq_r <= dsq_nxt;
      end
    end
  end

  assign push      = s1_valid_r & s1_last_r;
  assign push_data = {dot_nxt, na_nxt, nb_nxt, dsq_nxt, s1_ovf_r};

endmodule

// ===== design/vcds_queue.sv =====
// Small FIFO of finished vector sums between front and back.
module vcds_queue #(
  parameter int DATA_W = 157,
  parameter int DEPTH  = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [DATA_W-1:0]                wdata,
  input  logic                             pop,
  output logic [DATA_W-1:0]                rdata,
  output logic                             not_empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);
  import vcds_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [DATA_W-1:0]          mem_r [DEPTH];
  logic [PW-1:0]              wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  assign rdata     = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

// ===== design/vcds_back.sv =====
// Back end: shared bit-serial square root and divider producing both similarities.
module vcds_back #(
  parameter int ELEM_WIDTH = 16,
  parameter int ACC_W      = 39
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [4*ACC_W:0]          q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [vcds_pkg::COS_W-1:0] out_cosine_sim,
  output logic [vcds_pkg::DIST_W-1:0]       out_distance_sim,
  output logic                      out_length_overflow
);
  import vcds_pkg::*;

  localparam int W   = ACC_W;
  localparam int SW  = (W + 1) / 2;
  localparam int DW  = 2 * SW;
  localparam int NW  = W + 16;
  localparam int F   = ELEM_WIDTH - 1;
  localparam int STW = $clog2(NW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQA  = 3'd1;
  localparam logic [2:0] S_SQB  = 3'd2;
  localparam logic [2:0] S_SQD  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIVC = 3'd5;
  localparam logic [2:0] S_DIVD = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]     state_r;
  logic [STW-1:0] step_r;

  logic signed [W-1:0] dot_r;
  logic [W-1:0]        nb_r, dsq_r;
  logic                na_zero_r, nb_zero_r, ovf_r;
  logic [SW-1:0]       ra_r, rb_r;
  logic [DW-1:0]       prod_r;
  logic                cos_ok_r, cos_neg_r;

  // square root unit
  logic [DW-1:0] sq_x_r;
  logic [SW:0]   sq_rem_r;
  logic [SW-1:0] sq_root_r;
  logic [SW+2:0] sq_trial, sq_t;
  logic          sq_ge;
  logic [SW-1:0] sq_root_nxt;

  // divider unit
  logic [NW-1:0] dv_num_r;
  logic [DW-1:0] dv_den_r, dv_rem_r;
  logic [DW:0]   dv_trial;
  logic          dv_ge;

  logic          sq_last, dv_last;
  logic [W-1:0]  dot_mag;
  logic [DW-1:0] dist_den;
  logic [NW-1:0] cos_num, dist_num, q_fin;

  // distance divisor held while the cosine division uses the shared divider
  logic [DW-1:0] dist_den_r;

  logic signed [COS_W-1:0] cos_r;
  logic [DIST_W-1:0]       dist_r;
  logic                    out_valid_r;

  assign sq_trial    = {sq_rem_r, sq_x_r[DW-1 -: 2]};
  assign sq_t        = {1'b0, sq_root_r, 2'b01};
  assign sq_ge       = (sq_trial >= sq_t);
  assign sq_root_nxt = {sq_root_r[SW-2:0], sq_ge};
  assign sq_last     = (step_r == STW'(SW - 1));

  assign dv_trial = {dv_rem_r, dv_num_r[NW-1]};
  assign dv_ge    = (dv_trial >= {1'b0, dv_den_r});
  assign dv_last  = (step_r == STW'(NW - 1));
  assign q_fin    = {dv_num_r[NW-2:0], dv_ge};

  assign dot_mag  = dot_r[W-1] ? W'(-dot_r) : W'(dot_r);
  assign cos_num  = {{(NW-W-FRAC_OUT){1'b0}}, dot_mag, {FRAC_OUT{1'b0}}}
                    + NW'(prod_r >> 1);
  assign dist_den = DW'(1) << F;
  assign q_pop    = (state_r == S_IDLE) & q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_SQA;
            step_r  <= '0;
          end
        end
        S_SQA, S_SQB, S_SQD: begin
          step_r <= sq_last ? '0 : step_r + 1'b1;
          if (sq_last) begin
            state_r <= (state_r == S_SQA) ? S_SQB :
                       (state_r == S_SQB) ? S_SQD : S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_DIVC;
          step_r  <= '0;
        end
        S_DIVC: begin
          step_r <= dv_last ? '0 : step_r + 1'b1;
          if (dv_last) state_r <= S_DIVD;
        end
        S_DIVD: begin
          step_r <= dv_last ? '0 : step_r + 1'b1;
          if (dv_last) begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          dot_r     <= q_data[4*W -: W];
          nb_r      <= q_data[2*W -: W];
          dsq_r     <= q_data[W -: W];
          ovf_r     <= q_data[0];
          na_zero_r <= (q_data[3*W -: W] == '0);
          nb_zero_r <= (q_data[2*W -: W] == '0);
          sq_x_r    <= DW'(q_data[3*W -: W]);
          sq_rem_r  <= '0;
          sq_root_r <= '0;
        end
      end
      S_SQA, S_SQB, S_SQD: begin
        sq_x_r    <= {sq_x_r[DW-3:0], 2'b00};
        sq_rem_r  <= sq_ge ? (SW+1)'(sq_trial - sq_t) : sq_trial[SW:0];
        sq_root_r <= sq_root_nxt;
        if (sq_last) begin
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          if (state_r == S_SQA) begin
            ra_r   <= sq_root_nxt;
            sq_x_r <= DW'(nb_r);
          end else if (state_r == S_SQB) begin
            rb_r   <= sq_root_nxt;
            sq_x_r <= DW'(dsq_r);
          end else begin
            dv_den_r <= dist_den + DW'(sq_root_nxt);
          end
        end
      end
      S_MUL: begin
        prod_r    <= ra_r * rb_r;
        cos_neg_r <= dot_r[W-1];
      end
      S_DIVC, S_DIVD: begin
        if (step_r == '0 && state_r == S_DIVC) begin
          cos_ok_r <= ~na_zero_r & ~nb_zero_r & (prod_r != '0);
        end
        dv_num_r <= q_fin;
        dv_rem_r <= dv_ge ? DW'(dv_trial - {1'b0, dv_den_r}) : dv_trial[DW-1:0];
        if (step_r == '0) begin
          // load the operands of this division and take the first step
          if (state_r == S_DIVC) begin
            dv_num_r <= {cos_num[NW-2:0], 1'b0};
            dv_rem_r <= DW'(cos_num[NW-1]) >= prod_r && prod_r != '0 ?
                        DW'(DW'(cos_num[NW-1]) - prod_r) : DW'(cos_num[NW-1]);
            dv_den_r <= prod_r;
          end else begin
            dv_num_r <= {dist_num[NW-2:0], 1'b0};
            dv_rem_r <= DW'(dist_num[NW-1]);
          end
        end
        if (dv_last) begin
          if (state_r == S_DIVC) begin
            if (!cos_ok_r) begin
              cos_r <= '0;
            end else if (cos_neg_r) begin
              cos_r <= (q_fin > NW'(32768)) ? COS_W'(-32768) : COS_W'(-q_fin);
            end else begin
              cos_r <= (q_fin > NW'(32767)) ? COS_W'(32767) : COS_W'(q_fin);
            end
            dv_den_r <= dist_den_r;
          end else begin
            dist_r <= (q_fin > NW'(32767)) ? DIST_W'(32767) : DIST_W'(q_fin);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_SQD) && sq_last) begin
      dist_den_r <= dist_den + DW'(sq_root_nxt);
    end
  end
  assign dist_num = (NW'(1) << (FRAC_OUT + F)) + NW'(dist_den_r >> 1);

  assign out_valid           = out_valid_r;
  assign out_cosine_sim      = cos_r;
  assign out_distance_sim    = dist_r;
  assign out_length_overflow = ovf_r;

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result shown outside output state");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_SQA))
    else $error("pop did not start root sequence");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(cos_r) && $stable(dist_r))
    else $error("stalled result changed");

endmodule

// ===== design/vector_cosine_and_distance_similarity_core.sv =====
// Top level of the streaming cosine / inverse distance similarity core.
//
// Input channel: one element pair per word (in_elem_a, in_elem_b, Q1.15) with
// in_last_elem marking the last pair of the two vectors. The front end takes
// one word per cycle while in_stall is low; a two-stage multiply/accumulate
// forms the dot product, both squared norms and the squared difference. Pairs
// beyond MAX_LEN are dropped and flagged in out_length_overflow.
// On the last pair the four sums go into a four-entry queue. The back end pulls
// them and runs a shared one-bit-per-cycle square root (three times), one
// multiply and a shared one-bit-per-cycle divider (twice), then offers the
// result word.
// Element words stream at one per cycle while in_stall is low; the back end
// works on one vector at a time and pops the next only after the result word
// is taken, and in_stall rises when the queue has two or fewer free entries.
// The result word is held in an output register until out_stall is low.
// Reset (rst_n low, synchronous) clears the sums, counters, queue and result valid.
module vector_cosine_and_distance_similarity_core #(
  parameter int MAX_LEN    = vcds_pkg::MAX_LEN_DEF,
  parameter int ELEM_WIDTH = vcds_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ELEM_WIDTH-1:0]         in_elem_a,
  input  logic signed [ELEM_WIDTH-1:0]         in_elem_b,
  input  logic                                 in_last_elem,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vcds_pkg::COS_W-1:0]    out_cosine_sim,
  output logic [vcds_pkg::DIST_W-1:0]          out_distance_sim,
  output logic                                 out_length_overflow
);
  import vcds_pkg::*;

  localparam int ACC_W  = acc_width(ELEM_WIDTH, MAX_LEN);
  localparam int DATA_W = 4 * ACC_W + 1;
  localparam int QCW    = $clog2(Q_DEPTH + 1);

  logic              accept, push, pop, q_valid;
  logic [DATA_W-1:0] push_data, q_data;
  logic [QCW-1:0]    q_count;

  assign in_stall = (q_count >= QCW'(Q_DEPTH - 2));
  assign accept   = in_valid & ~in_stall;

  vcds_front #(
    .MAX_LEN(MAX_LEN), .ELEM_WIDTH(ELEM_WIDTH), .ACC_W(ACC_W)
  ) u_front (
    .clk, .rst_n, .accept,
    .elem_a(in_elem_a), .elem_b(in_elem_b), .last_elem(in_last_elem),
    .push, .push_data
  );

  vcds_queue #(.DATA_W(DATA_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk, .rst_n, .push, .wdata(push_data), .pop,
    .rdata(q_data), .not_empty(q_valid), .count(q_count)
  );

  vcds_back #(.ELEM_WIDTH(ELEM_WIDTH), .ACC_W(ACC_W)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop(pop),
    .out_valid, .out_stall, .out_cosine_sim, .out_distance_sim,
    .out_length_overflow
  );

endmodule

// ===== tb/tb_vector_cosine_and_distance_similarity_core.sv =====
// Self-checking testbench for the vector cosine / inverse distance similarity core.
module tb_vector_cosine_and_distance_similarity_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN   = vcds_pkg::MAX_LEN_DEF;
  localparam int EW        = vcds_pkg::ELEM_WIDTH_DEF;
  localparam int N_RANDOM  = 1110;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [15:0] cosine_sim;
    logic [14:0]        distance_sim;
    logic               length_overflow;
  } sim_word_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    logic               has_exp;
    sim_word_t          exp;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_elem;
  logic signed [EW-1:0] in_elem_a, in_elem_b;
  logic out_valid, out_stall, out_length_overflow;
  logic signed [15:0] out_cosine_sim;
  logic [14:0] out_distance_sim;

  vector_cosine_and_distance_similarity_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_elem_a(in_elem_a), .in_elem_b(in_elem_b), .in_last_elem(in_last_elem),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cosine_sim(out_cosine_sim), .out_distance_sim(out_distance_sim),
    .out_length_overflow(out_length_overflow)
  );

  // predictor state
  longint dot_sum, norm_a_sum, norm_b_sum, diff_sq_sum;
  int pair_count;
  bit overflow_flag;

  sim_word_t expected_words[$];
  int n_errors, n_words, n_vectors, n_overflows;
  longint cycle_count;

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic sim_word_t similarity_of_sums();
    sim_word_t w;
    longint unsigned ra, rb, den, mag, q, dd;
    bit neg;
    w.cosine_sim = '0;
    if (norm_a_sum != 0 && norm_b_sum != 0) begin
      ra = int_sqrt(norm_a_sum);
      rb = int_sqrt(norm_b_sum);
      den = ra * rb;
      if (den != 0) begin
        neg = dot_sum < 0;
        mag = neg ? -dot_sum : dot_sum;
        q = ((mag << 15) + (den >> 1)) / den;
        if (neg) begin
          if (q > 32768) q = 32768;
          w.cosine_sim = 16'(-q);
        end else begin
          if (q > 32767) q = 32767;
          w.cosine_sim = 16'(q);
        end
      end
    end
    dd = (64'd1 << (EW - 1)) + int_sqrt(diff_sq_sum);
    q = ((64'd1 << (15 + EW - 1)) + (dd >> 1)) / dd;
    if (q > 32767) q = 32767;
    w.distance_sim = 15'(q);
    w.length_overflow = overflow_flag;
    return w;
  endfunction

  function automatic void clear_sums();
    dot_sum = 0; norm_a_sum = 0; norm_b_sum = 0; diff_sq_sum = 0;
    pair_count = 0; overflow_flag = 0;
  endfunction

  // returns 1 and the word when the pair closes a vector
  function automatic bit accumulate_pair(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic last, output sim_word_t w);
    longint sa, sb, d;
    sa = a; sb = b;
    if (pair_count < MAX_LEN) begin
      d = sa - sb;
      dot_sum += sa * sb;
      norm_a_sum += sa * sa;
      norm_b_sum += sb * sb;
      diff_sq_sum += d * d;
      pair_count++;
    end else begin
      overflow_flag = 1;
    end
    if (!last) return 0;
    w = similarity_of_sums();
    clear_sums();
    return 1;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  // result checker and receiver stall
  initial begin
    int gap;
    sim_word_t e;
    out_stall = 1;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_words++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_cosine_sim !== e.cosine_sim) begin
          $error("cosine_sim expected %0d got %0d", e.cosine_sim, out_cosine_sim);
          n_errors++;
        end
        if (out_distance_sim !== e.distance_sim) begin
          $error("distance_sim expected %0d got %0d", e.distance_sim, out_distance_sim);
          n_errors++;
        end
        if (out_length_overflow !== e.length_overflow) begin
          $error("length_overflow expected %0b got %0b", e.length_overflow,
                 out_length_overflow);
          n_errors++;
        end
      end
    end
  end

  stim_row_t dir_rows[$];

  function automatic void add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic stim_row_t mk(input int a, input int b, input bit last,
                                   input bit has_exp = 0, input int cs = 0,
                                   input int ds = 0, input bit ov = 0);
    stim_row_t r;
    r.a = 16'(a); r.b = 16'(b); r.last = last; r.has_exp = has_exp;
    r.exp.cosine_sim = 16'(cs); r.exp.distance_sim = 15'(ds);
    r.exp.length_overflow = ov;
    return r;
  endfunction

  task automatic send_pair(input stim_row_t r);
    sim_word_t w, got;
    int gap;
    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_elem_a <= r.a;
    in_elem_b <= r.b;
    in_last_elem <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (accumulate_pair(r.a, r.b, r.last, got)) begin
      n_vectors++;
      if (got.length_overflow) n_overflows++;
      w = r.has_exp ? r.exp : got;
      if (r.has_exp && w !== got)
        $display("note: table row differs from predictor");
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  initial begin
    int len, kind, base;
    stim_row_t r;
    n_errors = 0; n_words = 0; n_vectors = 0; n_overflows = 0;
    clear_sums();
    rst_n = 0; in_valid = 0; in_elem_a = 0; in_elem_b = 0; in_last_elem = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    add_row(mk(0, 0, 1, 1, 0, 32767, 0));            // both norms zero
    add_row(mk(32767, 32767, 1, 1, 32767, 32767, 0)); // identical
    add_row(mk(-32768, -32768, 1, 1, 32767, 32767, 0));
    add_row(mk(-32768, 32767, 1));                   // opposite extremes
    add_row(mk(32767, -32768, 1));
    add_row(mk(16384, 0, 1, 1, 0, 21845, 0));         // b norm zero
    add_row(mk(1, -1, 0));
    add_row(mk(-1, 1, 1));
    add_row(mk(12345, -54, 0));
    add_row(mk(-21846, 21845, 0));
    add_row(mk(-1, -1, 1));
    foreach (dir_rows[i]) send_pair(dir_rows[i]);
    // over-length vector, final pair dropped too
    for (int i = 0; i <= MAX_LEN + 1; i++)
      send_pair(mk(-32768, 32767, i == MAX_LEN + 1));
    // exactly MAX_LEN pairs
    for (int i = 0; i < MAX_LEN; i++) send_pair(mk(32767, -32768, i == MAX_LEN - 1));

    // sender holds off until the core has drained
    in_valid <= 0;
    while (expected_words.size() != 0) @(posedge clk);

    // random vectors
    for (int n = 0; n < N_RANDOM; ) begin
      kind = $urandom_range(0, 9);
      len = kind == 0 ? $urandom_range(MAX_LEN - 2, MAX_LEN + 4) : $urandom_range(1, 12);
      base = $urandom_range(0, 65535);
      for (int i = 0; i < len; i++) begin
        r.a = 16'($urandom_range(0, 65535));
        r.b = 16'($urandom_range(0, 65535));
        if (kind == 1) r.b = r.a;                       // identical vectors
        else if (kind == 2) r.b = r.a ^ 16'($urandom_range(0, 15));
        else if (kind == 3) r.b = -r.a;
        else if (kind == 4) r.a = 0;
        else if (kind == 5) begin
          r.a = 16'(base); r.b = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        end
        r.last = i == len - 1;
        r.has_exp = 0;
        send_pair(r);
        n++;
      end
    end
    in_valid <= 0;
    in_last_elem <= 0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d vectors (%0d over length) checked, %0d result words seen",
             n_vectors, n_overflows, n_words);
    if (n_errors == 0 && expected_words.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
